// ===== hdl/cc20_pkg.sv =====
// Package: shared constants and the quarter-round function of the ChaCha20 block core.
`default_nettype none
package cc20_pkg;
   localparam int unsigned DefDoubleRounds = 10;
   localparam int unsigned WordCount = 16;
   localparam int unsigned PairCount = 8;

   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646E;
   localparam logic [31:0] SIGMA2 = 32'h79622D32;
   localparam logic [31:0] SIGMA3 = 32'h6B206574;

   typedef enum logic [2:0] {
      CSR_KEY0   = 3'd0,
      CSR_KEY1   = 3'd1,
      CSR_KEY2   = 3'd2,
      CSR_KEY3   = 3'd3,
      CSR_NONCE0 = 3'd4,
      CSR_NONCE1 = 3'd5
   } csr_index_type;

   typedef logic [WordCount-1:0][31:0] state_type;

   function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
      rotl = (v << n) | (v >> (32 - n));
   endfunction

   // One half of a quarter round: first (rotations 16/12) or second (8/7).
   function automatic logic [127:0] qhalf(input logic [127:0] abcd, input logic second);
      logic [31:0] a, b, c, d;
      a = abcd[31:0];
      b = abcd[63:32];
      c = abcd[95:64];
      d = abcd[127:96];
      a = a + b;
      d = second ? rotl(d ^ a, 8) : rotl(d ^ a, 16);
      c = c + d;
      b = second ? rotl(b ^ c, 7) : rotl(b ^ c, 12);
      qhalf = {d, c, b, a};
   endfunction
endpackage
`default_nettype wire

// ===== hdl/cc20_cell.sv =====
// Cell: one column or diagonal round of ChaCha20 on a passing state, with its valid and original state.
`default_nettype none
module cc20_cell
   import cc20_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      diag,
   input  wire logic      valid_in,
   input  state_type      work_in,
   input  state_type      init_in,
   output logic           valid_out,
   output state_type      work_out,
   output state_type      init_out
);
   logic      valid_ff;
   state_type work_ff, s1, s2;
   state_type init_ff;

   // Quarter rounds for column or diagonal arrangement, two register-free halves.
   always_comb begin
      s1 = work_in;
      s2 = work_in;
      for (int q = 0; q < 4; q++) begin
         logic [3:0] ia, ib, ic, id;
         logic [127:0] r;
         ia = 4'(q);
         ib = diag ? 4'(4 + ((q + 1) % 4)) : 4'(4 + q);
         ic = diag ? 4'(8 + ((q + 2) % 4)) : 4'(8 + q);
         id = diag ? 4'(12 + ((q + 3) % 4)) : 4'(12 + q);
         r = qhalf({work_in[id], work_in[ic], work_in[ib], work_in[ia]}, 1'b0);
         r = qhalf(r, 1'b1);
         s1[ia] = r[31:0];
         s1[ib] = r[63:32];
         s1[ic] = r[95:64];
         s1[id] = r[127:96];
      end
      s2 = s1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      work_ff <= s2;
      init_ff <= init_in;
   end

   assign valid_out = valid_ff;
   assign work_out  = work_ff;
   assign init_out  = init_ff;
endmodule
`default_nettype wire

// ===== hdl/cc20_serializer.sv =====
// Serializer: final addition and output of the eight 64-bit keystream pairs.
`default_nettype none
module cc20_serializer
   import cc20_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        valid_in,
   input  state_type        work_in,
   input  state_type        init_in,
   output logic             rsp_valid,
   output logic [63:0]      rsp_keystream_pair,
   output logic [2:0]       rsp_pair_index,
   output logic             rsp_last_pair
);
   state_type   sum_ff, sum_in;
   logic [2:0]  idx_ff, idx_in;
   logic        act_ff, act_in;

   always_comb begin
      sum_in = sum_ff;
      idx_in = idx_ff;
      act_in = act_ff;
      if (valid_in) begin
         for (int i = 0; i < WordCount; i++) sum_in[i] = work_in[i] + init_in[i];
         idx_in = 3'd0;
         act_in = 1'b1;
      end else if (act_ff) begin
         idx_in = idx_ff + 3'd1;
         act_in = (idx_ff != 3'd7);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
         idx_ff <= 3'd0;
      end else begin
         act_ff <= act_in;
         idx_ff <= idx_in;
      end
      sum_ff <= sum_in;
   end

   assign rsp_valid          = act_ff;
   assign rsp_keystream_pair = {sum_ff[{idx_ff, 1'b1}], sum_ff[{idx_ff, 1'b0}]};
   assign rsp_pair_index     = idx_ff;
   assign rsp_last_pair      = (idx_ff == 3'd7);
endmodule
`default_nettype wire

// ===== hdl/chacha20_block_keystream_top.sv =====
// Top level: ChaCha20 block keystream generator built as a chain of round cells.
//
// Usage:
//   Write the key (four 64-bit parts) and the nonce (64 + 32 bits) over the
//   csr_ port while idle; index i selects the i-th register, other indexes drop.
//   Raise req_start with req_block_counter; the transaction is accepted when
//   req_busy is low. Each accepted counter enters a chain of 2*DOUBLE_ROUNDS
//   cells, one column or diagonal round per cell, advancing every cycle.
//   Each block passes the cell registers and the serializer register to the
//   first rsp_ pair, then eight consecutive pairs, rsp_valid high for one
//   cycle each, last one marked by rsp_last_pair. The receiver cannot stall
//   the rsp_ channel. The output rate is set by the 64-bit output port; the
//   chain itself could take a counter every cycle, so req_busy spaces starts
//   to match the port while several blocks are in flight in the chain.
//   Reset clears the key, the nonce, all valid bits, the spacing counter and the output sequencer.
`default_nettype none
module chacha20_block_keystream_top
   import cc20_pkg::*;
#(
   parameter int unsigned DOUBLE_ROUNDS = DefDoubleRounds
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_start,
   input  wire logic [31:0] req_block_counter,
   output logic             req_busy,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data,
   output logic             rsp_valid,
   output logic [63:0]      rsp_keystream_pair,
   output logic [2:0]       rsp_pair_index,
   output logic             rsp_last_pair
);
   localparam int unsigned Cells = 2 * DOUBLE_ROUNDS;

   logic [3:0][63:0] key_ff;
   logic [63:0]      nonce_lo_ff;
   logic [31:0]      nonce_hi_ff;
   logic [2:0]       gap_ff, gap_in;
   logic             accept;
   state_type        init_st;

   logic      [Cells:0] vld;
   state_type           wrk [Cells+1];
   state_type           ini [Cells+1];

   // Hold configuration; ignore unknown indexes.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff      <= '0;
         nonce_lo_ff <= '0;
         nonce_hi_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY0:   key_ff[0]   <= csr_data;
            CSR_KEY1:   key_ff[1]   <= csr_data;
            CSR_KEY2:   key_ff[2]   <= csr_data;
            CSR_KEY3:   key_ff[3]   <= csr_data;
            CSR_NONCE0: nonce_lo_ff <= csr_data;
            CSR_NONCE1: nonce_hi_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // Space transactions with a gap counter to match the output port.
   assign req_busy = (gap_ff != 3'd0);
   assign accept   = req_start && !req_busy;
   always_comb begin
      gap_in = gap_ff;
      if (accept) gap_in = 3'd7;
      else if (gap_ff != 3'd0) gap_in = gap_ff - 3'd1;
   end
   always_ff @(posedge clock) begin
      if (reset) gap_ff <= 3'd0;
      else       gap_ff <= gap_in;
   end

   always_comb begin
      init_st[0]  = SIGMA0;
      init_st[1]  = SIGMA1;
      init_st[2]  = SIGMA2;
      init_st[3]  = SIGMA3;
      for (int i = 0; i < 4; i++) begin
         init_st[4 + 2*i] = key_ff[i][31:0];
         init_st[5 + 2*i] = key_ff[i][63:32];
      end
      init_st[12] = req_block_counter;
      init_st[13] = nonce_lo_ff[31:0];
      init_st[14] = nonce_lo_ff[63:32];
      init_st[15] = nonce_hi_ff;
   end

   assign vld[0] = accept;
   assign wrk[0] = init_st;
   assign ini[0] = init_st;

   for (genvar g = 0; g < Cells; g++) begin : g_cell
      cc20_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .diag      (1'(g % 2)),
         .valid_in  (vld[g]),
         .work_in   (wrk[g]),
         .init_in   (ini[g]),
         .valid_out (vld[g+1]),
         .work_out  (wrk[g+1]),
         .init_out  (ini[g+1])
      );
   end

   cc20_serializer u_ser (
      .clock              (clock),
      .reset              (reset),
      .valid_in           (vld[Cells]),
      .work_in            (wrk[Cells]),
      .init_in            (ini[Cells]),
      .rsp_valid          (rsp_valid),
      .rsp_keystream_pair (rsp_keystream_pair),
      .rsp_pair_index     (rsp_pair_index),
      .rsp_last_pair      (rsp_last_pair)
   );
endmodule
`default_nettype wire
